// ===== hw/rtl/ckc_pkg.sv =====
// Shared types, constants and register codes for the chained XOR keystream cipher.
package ckc_pkg;

  localparam int unsigned JOB_QUEUE_DEPTH = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 2'd2;

  // generator constants, Schrage form of x * 16807 mod (2^31 - 1), plus GEN_ADD
  localparam logic [31:0] GEN_M    = 32'h834E_0B5F;
  localparam logic [16:0] GEN_Q    = 17'h1_F31D;
  localparam logic [31:0] GEN_A    = 32'd16807;
  localparam logic [31:0] GEN_R    = 32'd2836;
  localparam logic [31:0] GEN_ADD  = 32'd123;
  localparam logic [31:0] GEN_WRAP = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] key;
    logic        enable;
    logic        decrypt;
  } ckc_cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  cnt_m1;
    logic        last;
    logic        xform;
    logic        decrypt;
    logic        load;
  } ckc_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_PRD,
    ST_SUM,
    ST_MIX,
    ST_EMIT
  } ckc_state_t;

endpackage

// ===== hw/rtl/ckc_stream_if.sv =====
// Valid/ready byte stream interface with last-byte flag.
interface ckc_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;
  logic       last;

  modport source(output valid, output octet, output last, input ready);
  modport sink(input valid, input octet, input last, output ready);
endinterface

// ===== hw/rtl/chained_xor_keystream_cipher_top.sv =====
// Top level of the chained XOR keystream cipher.
//
// in_ch carries packet bytes with a last-byte flag; out_ch returns the same
// number of bytes in the same order, with last on the final byte of a packet.
// Both use valid/ready: a byte moves on a clock edge where both are high.
// cfg_we/cfg_index/cfg_wdata write the key (index 0), enable (1) and decrypt
// mode (2); write them only while no packet is in flight.
// Bytes 0 (and 1 after a zero byte 0) and all bytes while disabled pass
// through: each job is popped in the idle state and emitted from ST_EMIT.
// Payload is gathered into 32-bit words; a full word (or the packet tail)
// goes through two passes of the 4-stage generator step (multiply,
// remainder, products, sum) plus the mix, then out at one byte per cycle
// while out_ch.ready is high; only then is the next job popped.
// A 4-entry job queue lets in_ch keep accepting while out_ch is stalled; when
// it fills, in_ch.ready drops. Output bytes hold while out_ch.ready is low.
// Synchronous reset clears the config and control state, empties the queue
// and puts the block at the start of a packet; no clearing pass is needed.
module chained_xor_keystream_cipher_top #(
  parameter int unsigned Q_DEPTH = ckc_pkg::JOB_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ckc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ckc_stream_if.sink                     in_ch,
  ckc_stream_if.source                   out_ch
);
  import ckc_pkg::*;

  ckc_cfg_t cfg_r;
  ckc_job_t push_job, pop_job;
  logic     q_push, q_full, q_nonempty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY:     cfg_r.key     <= cfg_wdata;
        CFG_ENABLE:  cfg_r.enable  <= cfg_wdata[0];
        CFG_DECRYPT: cfg_r.decrypt <= cfg_wdata[0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  ckc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_s   (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  ckc_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .pop_job  (pop_job)
  );

  ckc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_nonempty (q_nonempty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_s      (out_ch)
  );

endmodule

// ===== hw/rtl/ckc_front.sv =====
// Front end: accept bytes, classify them and gather payload into jobs.
module ckc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ckc_pkg::ckc_cfg_t cfg,
  ckc_stream_if.sink        in_s,
  input  logic              q_full,
  output logic              q_push,
  output ckc_pkg::ckc_job_t q_job
);
  import ckc_pkg::*;

  logic        first_r, first_nxt;
  logic        second_r, second_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic        acc;
  logic [31:0] word;

  assign in_s.ready = !q_full;
  assign acc        = in_s.valid && !q_full;
  assign word       = {8'd0, pend_r} | ({24'd0, in_s.octet} << {pcnt_r, 3'b000});

  always_comb begin
    first_nxt        = first_r;
    second_nxt       = second_r;
    pend_nxt         = pend_r;
    pcnt_nxt         = pcnt_r;
    q_push           = 1'b0;
    q_job.word       = {24'd0, in_s.octet};
    q_job.cnt_m1     = 2'd0;
    q_job.last       = in_s.last;
    q_job.xform      = 1'b0;
    q_job.decrypt    = cfg.decrypt;
    q_job.load       = 1'b0;
    if (acc) begin
      if (first_r) begin
        q_push     = 1'b1;
        q_job.load = 1'b1;
        first_nxt  = 1'b0;
        second_nxt = (in_s.octet == 8'd0);
        pend_nxt   = '0;
        pcnt_nxt   = '0;
      end else if (second_r) begin
        q_push     = 1'b1;
        second_nxt = 1'b0;
      end else if (!cfg.enable) begin
        q_push       = 1'b1;
        q_job.word   = word;
        q_job.cnt_m1 = pcnt_r;
        pend_nxt     = '0;
        pcnt_nxt     = '0;
      end else if (pcnt_r != 2'd3 && !in_s.last) begin
        pend_nxt = word[23:0];
        pcnt_nxt = pcnt_r + 2'd1;
      end else begin
        q_push       = 1'b1;
        q_job.word   = word;
        q_job.cnt_m1 = pcnt_r;
        q_job.xform  = 1'b1;
        pend_nxt     = '0;
        pcnt_nxt     = '0;
      end
      if (in_s.last) begin
        first_nxt  = 1'b1;
        second_nxt = 1'b0;
        pend_nxt   = '0;
        pcnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= 1'b1;
      second_r <= 1'b0;
      pend_r   <= '0;
      pcnt_r   <= '0;
    end else begin
      first_r  <= first_nxt;
      second_r <= second_nxt;
      pend_r   <= pend_nxt;
      pcnt_r   <= pcnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/ckc_queue.sv =====
// Short job queue between front end and back end.
module ckc_queue #(
  parameter int unsigned DEPTH = ckc_pkg::JOB_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ckc_pkg::ckc_job_t push_job,
  output logic              full,
  output logic              nonempty,
  input  logic              pop,
  output ckc_pkg::ckc_job_t pop_job
);
  import ckc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ckc_job_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_job  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/ckc_back.sv =====
// Back end: keystream generator, word chaining and byte output.
module ckc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ckc_pkg::ckc_cfg_t cfg,
  input  logic              q_nonempty,
  input  ckc_pkg::ckc_job_t q_job,
  output logic              q_pop,
  ckc_stream_if.source      out_s
);
  import ckc_pkg::*;

  ckc_state_t  state_r, state_nxt;
  ckc_job_t    job_r;
  logic [31:0] seed_r;
  logic [31:0] chain_r;
  logic [15:0] quot_r;
  logic [16:0] rem_r;
  logic [31:0] p1_r, p2_r;
  logic [15:0] ks_lo_r, ks_hi_r;
  logic        step_r;
  logic [31:0] res_r;
  logic [1:0]  idx_r;

  logic [63:0] prod;
  logic [33:0] qq, diff, rem_fix;
  logic [31:0] gen_n, gen_fix;
  logic [31:0] mixed;
  logic        out_acc;

  assign prod    = 64'(seed_r) * 64'(GEN_M);
  assign qq      = 34'(quot_r) * 34'(GEN_Q);
  assign diff    = 34'(seed_r) - qq;
  assign rem_fix = diff[33] ? diff + 34'(GEN_Q) : diff;
  assign gen_n   = p1_r - p2_r + GEN_ADD;
  assign gen_fix = gen_n[31] ? gen_n + GEN_WRAP : gen_n;
  assign mixed   = chain_r ^ {ks_hi_r, ks_lo_r} ^ job_r.word;
  assign out_acc = out_s.valid && out_s.ready;

  assign out_s.octet = 8'(res_r >> {idx_r, 3'b000});
  assign out_s.last  = job_r.last && (idx_r == job_r.cnt_m1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_nonempty) begin
          state_nxt = q_job.xform ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: state_nxt = ST_MOD;
      ST_MOD: state_nxt = ST_PRD;
      ST_PRD: state_nxt = ST_SUM;
      ST_SUM: state_nxt = step_r ? ST_MIX : ST_MUL;
      ST_MIX: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc && idx_r == job_r.cnt_m1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    out_s.valid = 1'b0;
    case (state_r)
      ST_IDLE: q_pop       = q_nonempty;
      ST_EMIT: out_s.valid = 1'b1;
      default: begin
        q_pop       = 1'b0;
        out_s.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seed_r  <= '0;
      chain_r <= '0;
      step_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (q_nonempty) begin
            job_r  <= q_job;
            res_r  <= q_job.word;
            step_r <= 1'b0;
            idx_r  <= '0;
            if (q_job.load) begin
              seed_r  <= cfg.key;
              chain_r <= cfg.key;
            end
          end
        end
        ST_MUL: quot_r <= prod[63:48];
        ST_MOD: rem_r  <= rem_fix[16:0];
        ST_PRD: begin
          p1_r <= 32'(rem_r) * GEN_A;
          p2_r <= 32'(quot_r) * GEN_R;
        end
        ST_SUM: begin
          seed_r <= gen_fix;
          step_r <= 1'b1;
          if (step_r) begin
            ks_hi_r <= gen_fix[15:0];
          end else begin
            ks_lo_r <= gen_fix[15:0];
          end
        end
        ST_MIX: begin
          res_r   <= mixed;
          chain_r <= job_r.decrypt ? job_r.word : mixed;
        end
        ST_EMIT: begin
          if (out_acc) begin
            idx_r <= idx_r + 2'd1;
          end
        end
        default: idx_r <= idx_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ckc_checker.sv =====
// Port-level checker for the cipher top level, with its bind.
module ckc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_octet,
  input logic       out_last
);
  logic [11:0] pend_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 12'(in_acc) - 12'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_octet) && $stable(out_last))
    else $error("output word changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 12'd0)
    else $error("output word without a matching input word");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind chained_xor_keystream_cipher_top ckc_checker u_ckc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_octet (out_ch.octet),
  .out_last  (out_ch.last)
);

// ===== bench/chained_xor_keystream_cipher_top_test.sv =====
// Self-checking testbench for the chained XOR keystream cipher top level.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] octet;
  logic       last;
} cipher_byte_t;

class cipher_byte_scoreboard;
  localparam int unsigned MAX_PKT_BYTES = 520;

  logic [31:0]  key_reg;
  logic         enable_reg;
  logic         decrypt_reg;
  logic [31:0]  gen_state;
  logic [31:0]  chain;
  logic [23:0]  held;
  logic [1:0]   held_cnt;
  logic [9:0]   pos;
  logic [1:0]   pay_start;
  cipher_byte_t expected_bytes[$];
  int unsigned  errors;

  function new();
    key_reg     = '0;
    enable_reg  = 1'b0;
    decrypt_reg = 1'b0;
    gen_state   = '0;
    chain       = '0;
    held        = '0;
    held_cnt    = '0;
    pos         = '0;
    pay_start   = 2'd1;
    errors      = 0;
  endfunction

  function logic [31:0] park_miller_step(logic [31:0] s);
    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] n;
    prod = {32'd0, s} * 64'h0000_0000_834E_0B5F;
    quot = {16'd0, prod[63:48]};
    n = (s % 32'h0001_F31D) * 32'd16807 - quot * 32'd2836 + 32'd123;
    if (n[31]) begin
      n = n + 32'h7FFF_FFFF;
    end
    return n;
  endfunction

  function void expect_byte(logic [7:0] b, logic l);
    cipher_byte_t e;
    e.octet = b;
    e.last  = l;
    expected_bytes.push_back(e);
  endfunction

  function void predict_cipher_bytes(logic [7:0] b, logic l);
    logic [31:0] word;
    logic [31:0] ks;
    logic [31:0] res;
    logic [2:0]  have;
    logic [9:0]  at;
    int          i;
    at = pos;
    if (pos < MAX_PKT_BYTES) begin
      pos = pos + 10'd1;
    end
    if (at == 10'd0) begin
      gen_state = key_reg;
      chain     = key_reg;
      held      = '0;
      held_cnt  = '0;
      pay_start = (b == 8'd0) ? 2'd2 : 2'd1;
      expect_byte(b, l);
    end else if (at == 10'd1 && pay_start == 2'd2) begin
      expect_byte(b, l);
    end else if (!enable_reg) begin
      for (i = 0; i < held_cnt; i++) begin
        expect_byte(held[8*i +: 8], 1'b0);
      end
      held     = '0;
      held_cnt = '0;
      expect_byte(b, l);
    end else begin
      word = {8'd0, held} | ({24'd0, b} << (8 * held_cnt));
      have = {1'b0, held_cnt} + 3'd1;
      if (have < 3'd4 && !l) begin
        held     = word[23:0];
        held_cnt = have[1:0];
      end else begin
        gen_state    = park_miller_step(gen_state);
        ks[15:0]     = gen_state[15:0];
        gen_state    = park_miller_step(gen_state);
        ks[31:16]    = gen_state[15:0];
        res          = chain ^ ks ^ word;
        chain        = decrypt_reg ? word : res;
        for (i = 0; i < have; i++) begin
          expect_byte(res[8*i +: 8], (i + 1 == have) ? l : 1'b0);
        end
        held     = '0;
        held_cnt = '0;
      end
    end
    if (l) begin
      held      = '0;
      held_cnt  = '0;
      pos       = '0;
      pay_start = 2'd1;
    end
  endfunction

  function void check_cipher_byte(logic [7:0] b, logic l);
    cipher_byte_t want;
    if (expected_bytes.size() == 0) begin
      $error("unexpected output word: out_byte %02h out_last %0b", b, l);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    if (b !== want.octet) begin
      $error("out_byte mismatch: expected %02h, actual %02h", want.octet, b);
      errors++;
    end
    if (l !== want.last) begin
      $error("out_last mismatch: expected %0b, actual %0b", want.last, l);
      errors++;
    end
  endfunction
endclass

module chained_xor_keystream_cipher_top_test;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 350;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [ckc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ckc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ckc_stream_if in_ch();
  ckc_stream_if out_ch();

  cipher_byte_scoreboard sb;
  logic [7:0]            pkt[$];
  logic                  src_gaps;
  logic                  sink_stalls;
  int unsigned           cycle_count;

  chained_xor_keystream_cipher_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        sb.predict_cipher_bytes(in_ch.octet, in_ch.last);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        sb.check_cipher_byte(out_ch.octet, out_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $error("timeout with %0d output words outstanding", sb.expected_bytes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic set_regs(input logic [31:0] key, input logic en, input logic dec);
    cfg_we    <= 1'b1;
    cfg_index <= ckc_pkg::CFG_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_index <= ckc_pkg::CFG_ENABLE;
    cfg_wdata <= {31'd0, en};
    @(posedge clk);
    cfg_index <= ckc_pkg::CFG_DECRYPT;
    cfg_wdata <= {31'd0, dec};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.key_reg     = key;
    sb.enable_reg  = en;
    sb.decrypt_reg = dec;
  endtask

  task automatic send_packet();
    int i;
    for (i = 0; i < pkt.size(); i++) begin
      if (src_gaps && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.octet <= pkt[i];
      in_ch.last  <= (i == pkt.size() - 1);
      @(posedge clk);
      while (in_ch.ready !== 1'b1) @(posedge clk);
    end
  endtask

  task automatic fill_random_packet(input int unsigned len);
    int unsigned i;
    pkt.delete();
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: pkt.push_back(8'h00);
        1: pkt.push_back(8'hFF);
        default: pkt.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      pkt[0] = 8'h00;
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned ph;
    int unsigned n_pkts;
    int unsigned len;
    logic [31:0] key;
    sb           = new();
    cycle_count  = 0;
    src_gaps     = 1'b0;
    sink_stalls  = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.octet  = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at reset: pass through
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    pkt = '{8'hA5, 8'h00, 8'hFF};
    send_packet();
    settle();

    set_regs(32'hFFFF_FFFF, 1'b1, 1'b0);
    pkt = '{8'h00};
    send_packet();
    pkt = '{8'h00, 8'hFF};
    send_packet();
    pkt = '{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01};
    send_packet();
    pkt = '{8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    send_packet();
    settle();

    set_regs(32'h0000_0000, 1'b1, 1'b1);
    pkt = '{8'h01, 8'hAA, 8'h55, 8'hC3};
    send_packet();
    pkt = '{8'h02, 8'h10, 8'h20};
    send_packet();
    settle();

    // long packet, many chained words
    set_regs($urandom, 1'b1, 1'($urandom_range(0, 1)));
    fill_random_packet(64);
    send_packet();
    settle();

    sent = 0;
    ph   = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: key = 32'h0000_0000;
        1: key = 32'hFFFF_FFFF;
        2: key = 32'h7FFF_FFFF;
        3: key = 32'h8000_0000;
        default: key = $urandom;
      endcase
      set_regs(key, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
      n_pkts = $urandom_range(3, 8);
      repeat (n_pkts) begin
        src_gaps    = (ph % 4 != 3) && (sent < RANDOM_ITEMS - 80);
        sink_stalls = (ph % 3 != 2) && (sent < RANDOM_ITEMS - 80);
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        fill_random_packet(len);
        send_packet();
        sent += len;
      end
      settle();
      ph++;
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
